/* sv/spsw_pkg.sv */
package spsw_pkg;

   localparam int XW          = 56;
   localparam int TWO_PI_Q    = 105414357;
   localparam int PI_Q        = 52707179;
   localparam int HALF_PI_Q   = 26353589;
   localparam int DENSITY_MAX = 655360;
   localparam int UNIT_Q16    = 65536;

   localparam logic signed [XW-1:0] X_MAX = {1'b0, {(XW-1){1'b1}}};
   localparam logic signed [XW-1:0] X_MIN = {1'b1, {(XW-1){1'b0}}};

   // modulo reduction: one conditional subtract per bit position, three per stage
   localparam int RED_STEPS     = 30;
   localparam int RED_PER_STAGE = 3;
   localparam int RED_STAGES    = RED_STEPS / RED_PER_STAGE;
   localparam int RED_LAT       = RED_STAGES + 2;
   localparam int SINE_LAT      = 11;

   localparam logic [2:0] REG_DENSITY   = 3'd0;
   localparam logic [2:0] REG_STAGES    = 3'd1;
   localparam logic [2:0] REG_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_GAIN      = 3'd3;
   localparam logic [2:0] REG_WET       = 3'd4;

   localparam logic signed [32:0] SINE_COEF [6] = '{
      -33'sd27, 33'sd2959, -33'sd213044, 33'sd8947849, -33'sd178956971, 33'sd1073741824
   };

   typedef struct packed {
      logic [19:0] density;
      logic [4:0]  stages;
      logic [16:0] thresh;
      logic [16:0] gain;
      logic [16:0] wet;
   } cfg_type;

endpackage

/* sv/spsw_shape_stage.sv */
module spsw_shape_stage (
   input  logic                           clock,
   input  logic                           en,
   input  logic                           active,
   input  logic signed [spsw_pkg::XW-1:0] x_in,
   output logic signed [spsw_pkg::XW-1:0] x_out
);
   import spsw_pkg::*;

   logic [XW-1:0]        a_c;
   logic                 neg_ff, sat_ff, act_ff;
   logic [39:0]          a_ff;
   logic [39:0]          hh_ff, hl_ff, ll_ff;
   logic signed [XW-1:0] x_ff;
   logic [61:0]          low_sum;
   logic [57:0]          p_c;
   logic [57:0]          mag_c;
   logic signed [XW-1:0] res_c;
   logic signed [XW-1:0] x_out_ff;

   assign a_c = x_in[XW-1] ? (~x_in + 1'b1) : x_in;

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= x_in[XW-1];
         sat_ff <= (a_c[XW-1:40] != '0);
         act_ff <= active;
         x_ff   <= x_in;
         a_ff   <= a_c[39:0];
         hh_ff  <= 40'(a_c[39:20]) * 40'(a_c[39:20]);
         hl_ff  <= 40'(a_c[39:20]) * 40'(a_c[19:0]);
         ll_ff  <= 40'(a_c[19:0]) * 40'(a_c[19:0]);
      end
   end

   always_comb begin
      low_sum = (62'(hl_ff) << 21) + 62'(ll_ff);
      p_c     = (58'(hh_ff) << 16) + 58'(low_sum >> 24);
      mag_c   = 58'(a_ff) + p_c;
      if (sat_ff || (mag_c[57:55] != '0)) begin
         res_c = neg_ff ? X_MIN : X_MAX;
      end else if (neg_ff) begin
         res_c = -$signed(mag_c[XW-1:0]);
      end else begin
         res_c = $signed(mag_c[XW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_out_ff <= act_ff ? res_c : x_ff;
      end
   end

   assign x_out = x_out_ff;

endmodule

/* sv/spsw_reduce.sv */
module spsw_reduce (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [spsw_pkg::XW-1:0] x_in,
   output logic signed [25:0]             r_out,
   output logic                           above_out,
   output logic                           below_out
);
   import spsw_pkg::*;

   localparam int NS = RED_STAGES;

   logic [XW-1:0]        acc_ff   [NS+1];
   logic                 neg_ff   [NS+1];
   logic                 above_ff [NS+1];
   logic                 below_ff [NS+1];
   logic [XW-1:0]        acc_in   [NS+1];
   logic [XW-1:0]        v;
   logic [XW-1:0]        modc;
   logic [26:0]          rm;
   logic signed [27:0]   r0;
   logic signed [25:0]   r_ff;
   logic                 above_o_ff, below_o_ff;

   always_comb begin
      acc_in[0] = x_in[XW-1] ? (~x_in + 1'b1) : x_in;
      for (int s = 0; s < NS; s++) begin
         v = acc_ff[s];
         for (int j = 0; j < RED_PER_STAGE; j++) begin
            modc = XW'(TWO_PI_Q) << (RED_STEPS - 1 - s * RED_PER_STAGE - j);
            if (v >= modc) begin
               v = v - modc;
            end
         end
         acc_in[s+1] = v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0]   <= acc_in[0];
         neg_ff[0]   <= x_in[XW-1];
         above_ff[0] <= (x_in > XW'(HALF_PI_Q));
         below_ff[0] <= (x_in < -XW'(HALF_PI_Q));
         for (int s = 0; s < NS; s++) begin
            acc_ff[s+1]   <= acc_in[s+1];
            neg_ff[s+1]   <= neg_ff[s];
            above_ff[s+1] <= above_ff[s];
            below_ff[s+1] <= below_ff[s];
         end
      end
   end

   always_comb begin
      rm = acc_ff[NS][26:0];
      r0 = (neg_ff[NS] && (rm != '0)) ? (28'(TWO_PI_Q) - 28'(rm)) : 28'(rm);
      if (r0 >= 28'(PI_Q)) begin
         r0 = r0 - 28'(TWO_PI_Q);
      end
      if (r0 > 28'(HALF_PI_Q)) begin
         r0 = 28'(PI_Q) - r0;
      end else if (r0 < -28'(HALF_PI_Q)) begin
         r0 = -28'(PI_Q) - r0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff       <= r0[25:0];
         above_o_ff <= above_ff[NS];
         below_o_ff <= below_ff[NS];
      end
   end

   assign r_out     = r_ff;
   assign above_out = above_o_ff;
   assign below_out = below_o_ff;

endmodule

/* sv/spsw_sine.sv */
module spsw_sine #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [25:0]            r_in,
   input  logic                          above_in,
   input  logic                          below_in,
   input  logic signed [SAMPLE_BITS-1:0] dry_in,
   input  spsw_pkg::cfg_type             cfg,
   output logic signed [SAMPLE_BITS-1:0] y_out
);
   import spsw_pkg::*;

   localparam int SH30 = 31 - SAMPLE_BITS;
   localparam logic signed [35:0] OUT_HI = 36'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [35:0] OUT_LO = -OUT_HI - 36'sd1;

   logic signed [31:0]            t_c;
   logic signed [63:0]            tt_c;
   logic signed [31:0]            t_ff   [1:6];
   logic signed [32:0]            t2_ff  [1:5];
   logic signed [32:0]            s_ff   [2:6];
   logic signed [32:0]            s_in   [2:6];
   logic signed [65:0]            prod_c [1:5];
   logic signed [32:0]            s_prev;
   logic                          ab_ff  [1:7];
   logic                          be_ff  [1:7];
   logic signed [SAMPLE_BITS-1:0] dry_ff [1:9];
   logic signed [64:0]            ys_c;
   logic signed [34:0]            ysh_c;
   logic signed [31:0]            y_ff;
   logic signed [49:0]            yt_c;
   logic signed [50:0]            bias_c;
   logic signed [50:0]            bl_c;
   logic signed [31:0]            w_ff;
   logic signed [49:0]            wg_c;
   logic signed [31:0]            g_ff;
   logic signed [31:0]            dry_ext;
   logic signed [31:0]            dry30;
   logic signed [49:0]            p1_ff, p2_ff;
   logic signed [50:0]            msum;
   logic signed [34:0]            m_c;
   logic signed [35:0]            mq;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   assign t_c  = 32'(r_in) <<< 6;
   assign tt_c = 64'(t_c) * 64'(t_c);

   always_comb begin
      for (int i = 1; i <= 5; i++) begin
         s_prev      = (i == 1) ? SINE_COEF[0] : s_ff[(i == 1) ? 2 : i];
         prod_c[i]   = 66'(s_prev) * 66'(t2_ff[i]);
         s_in[i+1]   = SINE_COEF[i] + 33'(prod_c[i] >>> 30);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[1]   <= t_c;
         t2_ff[1]  <= 33'(tt_c >>> 30);
         ab_ff[1]  <= above_in;
         be_ff[1]  <= below_in;
         dry_ff[1] <= dry_in;
         for (int i = 1; i <= 5; i++) begin
            s_ff[i+1] <= s_in[i+1];
            t_ff[i+1] <= t_ff[i];
         end
         for (int i = 1; i <= 4; i++) begin
            t2_ff[i+1] <= t2_ff[i];
         end
         for (int i = 1; i <= 6; i++) begin
            ab_ff[i+1] <= ab_ff[i];
            be_ff[i+1] <= be_ff[i];
         end
         for (int i = 1; i <= 8; i++) begin
            dry_ff[i+1] <= dry_ff[i];
         end
      end
   end

   // sine, clamped to +-1.0
   always_comb begin
      ys_c  = 65'(t_ff[6]) * 65'(s_ff[6]);
      ysh_c = 35'(ys_c >>> 30);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (ysh_c > 35'sd1073741824) begin
            y_ff <= 32'sd1073741824;
         end else if (ysh_c < -35'sd1073741824) begin
            y_ff <= -32'sd1073741824;
         end else begin
            y_ff <= 32'(ysh_c);
         end
      end
   end

   // blend towards +-1 beyond pi/2
   always_comb begin
      yt_c   = 50'(y_ff) * 50'($signed({1'b0, cfg.thresh}));
      bias_c = $signed({3'b000, 18'(18'(UNIT_Q16) - 18'(cfg.thresh)), 30'b0});
      bl_c   = ab_ff[7] ? (51'(yt_c) + bias_c) : (51'(yt_c) - bias_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= (ab_ff[7] || be_ff[7]) ? 32'(bl_c >>> 16) : y_ff;
      end
   end

   assign wg_c = 50'(w_ff) * 50'($signed({1'b0, cfg.gain}));

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff <= 32'(wg_c >>> 16);
      end
   end

   assign dry_ext = 32'(dry_ff[9]);

   if (SH30 >= 0) begin : g_dry_up
      assign dry30 = dry_ext <<< SH30;
   end else begin : g_dry_down
      assign dry30 = dry_ext >>> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= 50'(g_ff) * 50'($signed({1'b0, cfg.wet}));
         p2_ff <= 50'(dry30) * 50'($signed({1'b0, 18'(18'(UNIT_Q16) - 18'(cfg.wet))}));
      end
   end

   assign msum = 51'(p1_ff) + 51'(p2_ff);
   assign m_c  = 35'(msum >>> 16);

   if (SH30 > 0) begin : g_rnd
      localparam logic signed [35:0] HALF_LSB = 36'(64'sd1 <<< (SH30 - 1));
      assign mq = (36'(m_c) + HALF_LSB) >>> SH30;
   end else if (SH30 == 0) begin : g_keep
      assign mq = 36'(m_c);
   end else begin : g_up
      assign mq = 36'(m_c) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (mq > OUT_HI) begin
            out_ff <= SAMPLE_BITS'(OUT_HI);
         end else if (mq < OUT_LO) begin
            out_ff <= SAMPLE_BITS'(OUT_LO);
         end else begin
            out_ff <= SAMPLE_BITS'(mq);
         end
      end
   end

   assign y_out = out_ff;

endmodule

/* sv/spsw_channel.sv */
module spsw_channel #(
   parameter int MAX_STAGES  = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  spsw_pkg::cfg_type             cfg,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);
   import spsw_pkg::*;

   localparam int DSH = SAMPLE_BITS - 9;
   localparam int PW  = SAMPLE_BITS + 21;
   localparam int PRE = 1 + 2 * MAX_STAGES + RED_LAT;
   localparam logic signed [PW-1:0] RND = PW'(64'sd1 <<< (DSH - 1));

   logic signed [PW-1:0]          drive_c;
   logic signed [XW-1:0]          x0_ff;
   logic signed [XW-1:0]          xs [MAX_STAGES+1];
   logic signed [SAMPLE_BITS-1:0] dry_ff [PRE];
   logic signed [25:0]            r;
   logic                          above, below;

   assign drive_c = PW'(sample_in) * PW'($signed({1'b0, cfg.density})) + RND;

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff     <= XW'(drive_c >>> DSH);
         dry_ff[0] <= sample_in;
         for (int i = 1; i < PRE; i++) begin
            dry_ff[i] <= dry_ff[i-1];
         end
      end
   end

   assign xs[0] = x0_ff;

   for (genvar g = 0; g < MAX_STAGES; g++) begin : g_shape
      spsw_shape_stage u_stage (
         .clock  (clock),
         .en     (en),
         .active (5'(g) < cfg.stages),
         .x_in   (xs[g]),
         .x_out  (xs[g+1])
      );
   end

   spsw_reduce u_reduce (
      .clock     (clock),
      .en        (en),
      .x_in      (xs[MAX_STAGES]),
      .r_out     (r),
      .above_out (above),
      .below_out (below)
   );

   spsw_sine #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sine (
      .clock    (clock),
      .en       (en),
      .r_in     (r),
      .above_in (above),
      .below_in (below),
      .dry_in   (dry_ff[PRE-1]),
      .cfg      (cfg),
      .y_out    (sample_out)
   );

endmodule

/* sv/stereo_polynomial_sine_waveshaper.sv */
// Throughput: one stereo beat per cycle while nothing stalls; every stage is a register,
// no shared unit. A stall on the result side while a result is waiting freezes the whole
// pipeline, so the input stalls with it.
// Reset (synchronous, active high) empties the pipeline and restores the registers:
// density 0, stages 0, threshold 0, output gain 1.0, wet 1.0.
module stereo_polynomial_sine_waveshaper #(
   parameter int MAX_STAGES  = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [4:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import spsw_pkg::*;

   localparam int LAT = 1 + 2 * MAX_STAGES + RED_LAT + SINE_LAT;

   logic [19:0]    density_ff;
   logic [3:0]     stages_ff;
   logic [16:0]    thresh_ff, gain_ff, wet_ff;
   logic [2:0]     idx;
   logic           wr;
   cfg_type        cfg;
   logic           adv;
   logic [LAT-1:0] valid_ff;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= '0;
         stages_ff  <= '0;
         thresh_ff  <= '0;
         gain_ff    <= 17'(UNIT_Q16);
         wet_ff     <= 17'(UNIT_Q16);
      end else if (wr) begin
         unique case (idx)
            REG_DENSITY:   density_ff <= csr_pwdata[19:0];
            REG_STAGES:    stages_ff  <= csr_pwdata[3:0];
            REG_THRESHOLD: thresh_ff  <= csr_pwdata[16:0];
            REG_GAIN:      gain_ff    <= csr_pwdata[16:0];
            REG_WET:       wet_ff     <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DENSITY:   csr_prdata = 32'(density_ff);
         REG_STAGES:    csr_prdata = 32'(stages_ff);
         REG_THRESHOLD: csr_prdata = 32'(thresh_ff);
         REG_GAIN:      csr_prdata = 32'(gain_ff);
         REG_WET:       csr_prdata = 32'(wet_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.density = (density_ff > 20'(DENSITY_MAX)) ? 20'(DENSITY_MAX) : density_ff;
      cfg.stages  = ({1'b0, stages_ff} > 5'(MAX_STAGES)) ? 5'(MAX_STAGES)
                                                         : {1'b0, stages_ff};
      cfg.thresh  = (thresh_ff > 17'(UNIT_Q16)) ? 17'(UNIT_Q16) : thresh_ff;
      cfg.gain    = (gain_ff > 17'(UNIT_Q16)) ? 17'(UNIT_Q16) : gain_ff;
      cfg.wet     = (wet_ff > 17'(UNIT_Q16)) ? 17'(UNIT_Q16) : wet_ff;
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   spsw_channel #(
      .MAX_STAGES  (MAX_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left (
      .clock      (clock),
      .en         (adv),
      .sample_in  (req_left_sample),
      .cfg        (cfg),
      .sample_out (rsp_left_out)
   );

   spsw_channel #(
      .MAX_STAGES  (MAX_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right (
      .clock      (clock),
      .en         (adv),
      .sample_in  (req_right_sample),
      .cfg        (cfg),
      .sample_out (rsp_right_out)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   a_stage_clamp: assert property (@(posedge clock) disable iff (reset)
      cfg.stages <= 5'(MAX_STAGES))
      else $error("stage count beyond pipeline depth");

endmodule

/* tb/tb_top.sv */
module tb_top;
   import spsw_pkg::*;

   localparam logic [2:0] REG_NONE = 3'd7;
   localparam int PIPE_LAT = 40;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_left_sample = '0;
   logic signed [23:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_left_out;
   logic signed [23:0] rsp_right_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   stereo_polynomial_sine_waveshaper dut (.*);

   always #5 clock = ~clock;

   // shadow copy of the registers
   logic [19:0] sh_density;
   logic [3:0]  sh_stages;
   logic [16:0] sh_thresh;
   logic [16:0] sh_gain;
   logic [16:0] sh_wet;

   pair_type shaped_q[$];
   int    n_fail = 0;
   int    n_beats = 0;
   int    n_results = 0;
   int    n_cfg = 0;
   bit    no_gaps = 0;
   bit    rx_quiet = 0;
   int    long_hold_req = 0;
   int    long_hold = 0;
   int    rx_wait = 0;

   function automatic longint stage_step(longint x);
      logic [127:0] a, sq;
      longint mag;
      bit neg;
      neg = x < 0;
      a = neg ? 128'(-x) : 128'(x);
      if (a >= (128'd1 << 40)) begin
         mag = longint'(1) << 55;
      end else begin
         sq = a * a;
         mag = longint'(a + (sq >> 24));
      end
      if (neg) begin
         if (mag >= (longint'(1) << 55)) return -(longint'(1) << 55);
         return -mag;
      end
      if (mag > (longint'(1) << 55) - 1) return (longint'(1) << 55) - 1;
      return mag;
   endfunction

   function automatic longint sine_of(longint x);
      longint coef [6] = '{-27, 2959, -213044, 8947849, -178956971, 1073741824};
      longint r, t, t2, s, y;
      r = x % longint'(TWO_PI_Q);
      if (r < 0) r += TWO_PI_Q;
      if (r >= PI_Q) r -= TWO_PI_Q;
      if (r > HALF_PI_Q) r = PI_Q - r;
      else if (r < -HALF_PI_Q) r = -PI_Q - r;
      t = r * 64;
      t2 = (t * t) >>> 30;
      s = coef[0];
      for (int i = 1; i < 6; i++) s = coef[i] + ((s * t2) >>> 30);
      y = (t * s) >>> 30;
      if (y > (longint'(1) << 30)) y = longint'(1) << 30;
      if (y < -(longint'(1) << 30)) y = -(longint'(1) << 30);
      return y;
   endfunction

   function automatic logic signed [23:0] shape_sample(logic signed [23:0] smp);
      longint d, th, g, w, n, x, y, m, one;
      d  = sh_density > DENSITY_MAX ? DENSITY_MAX : sh_density;
      th = sh_thresh > UNIT_Q16 ? UNIT_Q16 : sh_thresh;
      g  = sh_gain > UNIT_Q16 ? UNIT_Q16 : sh_gain;
      w  = sh_wet > UNIT_Q16 ? UNIT_Q16 : sh_wet;
      n  = sh_stages > 8 ? 8 : sh_stages;
      one = longint'(1) << 30;
      x = (longint'(smp) * d + (longint'(1) << 14)) >>> 15;
      for (int i = 0; i < n; i++) x = stage_step(x);
      y = sine_of(x);
      if (x > HALF_PI_Q) y = (y * th + (UNIT_Q16 - th) * one) >>> 16;
      else if (x < -HALF_PI_Q) y = (y * th - (UNIT_Q16 - th) * one) >>> 16;
      y = (y * g) >>> 16;
      m = (y * w + longint'(smp) * 128 * (UNIT_Q16 - w)) >>> 16;
      m = (m + 64) >>> 7;
      if (m > 8388607) m = 8388607;
      if (m < -8388608) m = -8388608;
      return 24'(m);
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DENSITY:   sh_density = value[19:0];
         REG_STAGES:    sh_stages = value[3:0];
         REG_THRESHOLD: sh_thresh = value[16:0];
         REG_GAIN:      sh_gain = value[16:0];
         REG_WET:       sh_wet = value[16:0];
         default: ;
      endcase
      n_cfg++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shaped_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   task automatic set_cfg(logic [31:0] dens, logic [31:0] stg, logic [31:0] thr,
                          logic [31:0] gn, logic [31:0] wt);
      drain();
      write_reg(REG_DENSITY, dens);
      write_reg(REG_STAGES, stg);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_GAIN, gn);
      write_reg(REG_WET, wt);
   endtask

   task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_sample <= l;
      req_right_sample <= r;
      do @(posedge clock); while (req_stall);
      shaped_q.push_back('{shape_sample(l), shape_sample(r)});
      n_beats++;
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'($urandom_range(0, 255)) - 24'sd128;
         1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         2: return 24'($urandom_range(0, 65535)) - 24'sd32768;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65536;
         2: return $urandom_range(65537, 131071);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   task automatic test_reset_values();
      send_pair(24'sh000000, 24'sh7fffff);
      send_pair(24'sh800000, 24'sh123456);
      send_pair(24'sh400000, 24'shc00000);
   endtask

   task automatic test_extremes();
      logic signed [23:0] edge_vals [6] = '{24'sh7fffff, 24'sh800000, 24'sh000000,
                                            24'sh000001, 24'shffffff, 24'sh555555};
      // full drive, all stages: deep saturation and blending toward +-1
      set_cfg(655360, 8, 0, 65536, 65536);
      foreach (edge_vals[i]) send_pair(edge_vals[i], edge_vals[5 - i]);
      // over-range registers are clamped, stage count above the maximum
      set_cfg(32'hfffff, 15, 32'h1ffff, 32'h1ffff, 32'h1ffff);
      foreach (edge_vals[i]) send_pair(edge_vals[i], ~edge_vals[i]);
      // zero gain, all dry; unknown register index ignored
      set_cfg(100000, 3, 65536, 0, 0);
      write_reg(REG_NONE, 32'hffffffff);
      foreach (edge_vals[i]) send_pair(edge_vals[i], edge_vals[i]);
      // no shaping, half threshold: sine of the driven sample, blended beyond pi/2
      set_cfg(655360, 0, 32768, 65536, 65536);
      send_pair(24'sh7fffff, 24'sh800000);
      send_pair(24'sh28f5c3, 24'shd70a3d);
   endtask

   task automatic test_random(int n_items);
      int per_phase;
      while (n_items > 0) begin
         set_cfg($urandom_range(0, 3) == 0 ? $urandom_range(0, 32'hfffff)
                                           : $urandom_range(0, 655360),
                 $urandom_range(0, 15), rand_q16(), rand_q16(), rand_q16());
         no_gaps = $urandom_range(0, 3) == 0;
         rx_quiet = $urandom_range(0, 3) == 0;
         per_phase = $urandom_range(20, 60);
         for (int i = 0; i < per_phase && n_items > 0; i++, n_items--)
            send_pair(rand_sample(), rand_sample());
      end
      no_gaps = 0;
      rx_quiet = 0;
   endtask

   task automatic test_backpressure();
      set_cfg(300000, 4, 40000, 60000, 50000);
      no_gaps = 1;
      long_hold_req = 300;
      for (int i = 0; i < 80; i++) send_pair(rand_sample(), rand_sample());
      no_gaps = 0;
      drain();
   endtask

   // result side: random stalls per beat, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_req > 0) begin
         long_hold = long_hold_req;
         long_hold_req = 0;
         rsp_stall <= 1'b1;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall && !rx_quiet) rx_wait = $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shaped_q.size() == 0) begin
            $error("result beat with nothing expected");
            n_fail++;
         end else begin
            want = shaped_q.pop_front();
            n_results++;
            if (rsp_left_out !== want.left) begin
               $error("left_out expected %0d got %0d", want.left, rsp_left_out);
               n_fail++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out expected %0d got %0d", want.right, rsp_right_out);
               n_fail++;
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      sh_density = 0;
      sh_stages = 0;
      sh_thresh = 0;
      sh_gain = 65536;
      sh_wet = 65536;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_extremes();
      test_backpressure();
      test_random(550);
      drain();
      if (shaped_q.size() != 0) begin
         $error("%0d results never arrived", shaped_q.size());
         n_fail++;
      end
      $display("Run covered %0d stereo beats, %0d results, %0d register writes,",
               n_beats, n_results, n_cfg);
      $display("directed extremes, clamped registers, long output hold and random phases.");
      if (n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/spsw_pkg.sv
sv/spsw_shape_stage.sv
sv/spsw_reduce.sv
sv/spsw_sine.sv
sv/spsw_channel.sv
sv/stereo_polynomial_sine_waveshaper.sv
tb/tb_top.sv
